>>> rtl/core/pfe_pkg.sv
`default_nettype none
package pfe_pkg;

  localparam int unsigned SIDE  = 5;
  localparam int unsigned ALPHA = 26;
  localparam int unsigned CELLS = 25;

  localparam logic [4:0] LETTER_I = 5'd8;
  localparam logic [4:0] LETTER_J = 5'd9;
  localparam logic [4:0] LETTER_X = 5'd23;
  localparam logic [4:0] LETTER_Z = 5'd25;
  localparam logic [4:0] LAST_LETTER = 5'(ALPHA - 1);
  localparam logic [4:0] CELL_COUNT  = 5'(CELLS);
  localparam logic [2:0] LAST_COORD  = 3'(SIDE - 1);

  localparam logic [1:0] CMD_KEY    = 2'd0;
  localparam logic [1:0] CMD_FINISH = 2'd1;
  localparam logic [1:0] CMD_MSG    = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_WALK,
    S_ERR,
    S_RD_A,
    S_RD_B,
    S_CALC,
    S_CELL1,
    S_EMIT1,
    S_CELL2,
    S_EMIT2
  } pfe_state_t;

  // controller -> datapath
  typedef struct packed {
    logic latch_in;
    logic key_place;
    logic walk_place;
    logic clear;
    logic msg_plan;
    logic rd_a;
    logic cap_a;
    logic calc;
    logic sel_idx2;
    logic emit_err;
    logic emit1;
    logic emit2;
    logic next_pair;
  } pfe_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] cmd;
    logic       key_ready;
    logic       pair_any;
    logic       pair_more;
    logic       walk_last;
    logic       out_free;
  } pfe_stat_t;

  // clamp to z, fold j into i
  function automatic logic [4:0] fold_letter(input logic [4:0] c);
    logic [4:0] t;
    t = (c > LETTER_Z) ? LETTER_Z : c;
    return (t == LETTER_J) ? LETTER_I : t;
  endfunction

  function automatic logic [2:0] wrap_inc(input logic [2:0] v);
    return (v == LAST_COORD) ? 3'd0 : v + 3'd1;
  endfunction

  function automatic logic [4:0] cell_index(input logic [2:0] row, input logic [2:0] col);
    return ({2'b00, row} << 2) + {2'b00, row} + {2'b00, col};
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/pfe_ram.sv
`default_nettype none
module pfe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/core/pfe_ctrl.sv
`default_nettype none
module pfe_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire pfe_pkg::pfe_stat_t stat,
  output pfe_pkg::pfe_cmd_t      cmd
);
  import pfe_pkg::*;

  pfe_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        case (stat.cmd)
          CMD_FINISH: state_nxt = stat.key_ready ? S_IDLE : S_WALK;
          CMD_MSG: begin
            if (!stat.key_ready) state_nxt = S_ERR;
            else if (stat.pair_any) state_nxt = S_RD_A;
            else state_nxt = S_IDLE;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_WALK: begin
        if (stat.walk_last) state_nxt = S_IDLE;
      end
      S_ERR: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      S_RD_A:  state_nxt = S_RD_B;
      S_RD_B:  state_nxt = S_CALC;
      S_CALC:  state_nxt = S_CELL1;
      S_CELL1: state_nxt = S_EMIT1;
      S_EMIT1: begin
        if (stat.out_free) state_nxt = S_CELL2;
      end
      S_CELL2: state_nxt = S_EMIT2;
      S_EMIT2: begin
        if (stat.out_free) state_nxt = stat.pair_more ? S_RD_A : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready     = 1'b1;
        cmd.latch_in = in_valid;
      end
      S_DECODE: begin
        cmd.key_place = (stat.cmd == CMD_KEY) && !stat.key_ready;
        cmd.clear     = (stat.cmd == CMD_CLEAR);
        cmd.msg_plan  = (stat.cmd == CMD_MSG) && stat.key_ready;
      end
      S_WALK:  cmd.walk_place = 1'b1;
      S_ERR:   cmd.emit_err   = stat.out_free;
      S_RD_A:  cmd.rd_a       = 1'b1;
      S_RD_B:  cmd.cap_a      = 1'b1;
      S_CALC:  cmd.calc       = 1'b1;
      S_CELL1: cmd.sel_idx2   = 1'b0;
      S_EMIT1: cmd.emit1      = stat.out_free;
      S_CELL2: cmd.sel_idx2   = 1'b1;
      S_EMIT2: begin
        cmd.sel_idx2  = 1'b1;
        cmd.emit2     = stat.out_free;
        cmd.next_pair = stat.out_free && stat.pair_more;
      end
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/core/pfe_dp.sv
`default_nettype none
module pfe_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pfe_pkg::pfe_cmd_t cmd,
  output pfe_pkg::pfe_stat_t     stat,
  input  wire logic [1:0]        in_cmd,
  input  wire logic [4:0]        in_letter,
  input  wire logic              in_last,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output logic [4:0]             out_cipher_letter,
  output logic                   out_run_last,
  output logic                   out_message_end,
  output logic                   out_not_keyed
);
  import pfe_pkg::*;

  // latched request
  logic [1:0] cmd_r, cmd_nxt;
  logic [4:0] let_r, let_nxt;
  logic       last_r, last_nxt;

  // key square bookkeeping
  logic [ALPHA-1:0] used_r, used_nxt;
  logic [4:0]       filled_r, filled_nxt;
  logic [2:0]       fill_row_r, fill_row_nxt;
  logic [2:0]       fill_col_r, fill_col_nxt;
  logic             key_ready_r, key_ready_nxt;
  logic [4:0]       walk_k_r, walk_k_nxt;

  // pairing
  logic [4:0] held_r, held_nxt;
  logic       held_valid_r, held_valid_nxt;
  logic [4:0] cur_a_r, cur_a_nxt;
  logic [4:0] cur_b_r, cur_b_nxt;
  logic [4:0] nxt_a_r, nxt_a_nxt;
  logic       more_r, more_nxt;

  // coordinates and cell addresses
  logic [2:0] ra_r, ra_nxt;
  logic [2:0] ca_r, ca_nxt;
  logic [4:0] idx1_r, idx1_nxt;
  logic [4:0] idx2_r, idx2_nxt;

  // result register
  logic       out_valid_r, out_valid_nxt;
  logic [4:0] out_let_r, out_let_nxt;
  logic       out_rl_r, out_rl_nxt;
  logic       out_me_r, out_me_nxt;
  logic       out_nk_r, out_nk_nxt;

  logic       out_free;
  logic [4:0] place_let;
  logic       place_en;
  logic       dup;
  logic [5:0] place_rdata;
  logic [4:0] sq_rdata;
  logic [2:0] rb, cb;
  logic [2:0] r1, c1, r2, c2;

  assign out_free  = !out_valid_r || out_ready;
  assign place_let = cmd.walk_place ? walk_k_r : let_r;
  assign place_en  = (cmd.key_place || (cmd.walk_place && walk_k_r != LETTER_J))
                     && !used_r[place_let] && (filled_r != CELL_COUNT);
  assign dup       = (held_r == let_r) && (let_r != LETTER_X);

  assign rb = place_rdata[5:3];
  assign cb = place_rdata[2:0];

  always_comb begin
    r1 = ra_r;
    c1 = ca_r;
    r2 = rb;
    c2 = cb;
    if (ra_r == rb) begin
      c1 = wrap_inc(ca_r);
      c2 = wrap_inc(cb);
    end else if (ca_r == cb) begin
      r1 = wrap_inc(ra_r);
      r2 = wrap_inc(rb);
    end else begin
      c1 = cb;
      c2 = ca_r;
    end
  end

  pfe_ram #(.WIDTH(6), .DEPTH(ALPHA)) u_place_ram (
    .clk   (clk),
    .we    (place_en),
    .waddr (place_let),
    .wdata ({fill_row_r, fill_col_r}),
    .raddr (cmd.rd_a ? cur_a_r : cur_b_r),
    .rdata (place_rdata)
  );

  pfe_ram #(.WIDTH(5), .DEPTH(CELLS)) u_square_ram (
    .clk   (clk),
    .we    (place_en),
    .waddr (filled_r),
    .wdata (place_let),
    .raddr (cmd.sel_idx2 ? idx2_r : idx1_r),
    .rdata (sq_rdata)
  );

  always_comb begin
    cmd_nxt        = cmd_r;
    let_nxt        = let_r;
    last_nxt       = last_r;
    used_nxt       = used_r;
    filled_nxt     = filled_r;
    fill_row_nxt   = fill_row_r;
    fill_col_nxt   = fill_col_r;
    key_ready_nxt  = key_ready_r;
    walk_k_nxt     = walk_k_r;
    held_nxt       = held_r;
    held_valid_nxt = held_valid_r;
    cur_a_nxt      = cur_a_r;
    cur_b_nxt      = cur_b_r;
    nxt_a_nxt      = nxt_a_r;
    more_nxt       = more_r;
    ra_nxt         = ra_r;
    ca_nxt         = ca_r;
    idx1_nxt       = idx1_r;
    idx2_nxt       = idx2_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_let_nxt    = out_let_r;
    out_rl_nxt     = out_rl_r;
    out_me_nxt     = out_me_r;
    out_nk_nxt     = out_nk_r;

    if (cmd.latch_in) begin
      cmd_nxt    = in_cmd;
      let_nxt    = fold_letter(in_letter);
      last_nxt   = in_last;
      walk_k_nxt = '0;
    end

    if (place_en) begin
      used_nxt[place_let] = 1'b1;
      filled_nxt          = filled_r + 5'd1;
      if (fill_col_r == LAST_COORD) begin
        fill_col_nxt = '0;
        fill_row_nxt = fill_row_r + 3'd1;
      end else begin
        fill_col_nxt = fill_col_r + 3'd1;
      end
    end

    if (cmd.walk_place) begin
      walk_k_nxt = walk_k_r + 5'd1;
      if (walk_k_r == LAST_LETTER) key_ready_nxt = 1'b1;
    end

    if (cmd.clear) begin
      used_nxt       = '0;
      filled_nxt     = '0;
      fill_row_nxt   = '0;
      fill_col_nxt   = '0;
      key_ready_nxt  = 1'b0;
      held_valid_nxt = 1'b0;
      held_nxt       = '0;
    end

    if (cmd.msg_plan) begin
      more_nxt = 1'b0;
      if (held_valid_r) begin
        if (dup) begin
          // doubled pair: held letter takes x, new letter becomes held
          cur_a_nxt      = held_r;
          cur_b_nxt      = LETTER_X;
          nxt_a_nxt      = let_r;
          more_nxt       = last_r;
          held_nxt       = let_r;
          held_valid_nxt = !last_r;
        end else begin
          cur_a_nxt      = held_r;
          cur_b_nxt      = let_r;
          held_valid_nxt = 1'b0;
        end
      end else begin
        cur_a_nxt      = let_r;
        cur_b_nxt      = LETTER_X;
        held_nxt       = let_r;
        held_valid_nxt = !last_r;
      end
    end

    if (cmd.next_pair) begin
      cur_a_nxt = nxt_a_r;
      cur_b_nxt = LETTER_X;
      more_nxt  = 1'b0;
    end

    if (cmd.cap_a) begin
      ra_nxt = place_rdata[5:3];
      ca_nxt = place_rdata[2:0];
    end

    if (cmd.calc) begin
      idx1_nxt = cell_index(r1, c1);
      idx2_nxt = cell_index(r2, c2);
    end

    if (cmd.emit_err) begin
      out_valid_nxt = 1'b1;
      out_let_nxt   = '0;
      out_rl_nxt    = 1'b1;
      out_me_nxt    = 1'b0;
      out_nk_nxt    = 1'b1;
    end else if (cmd.emit1) begin
      out_valid_nxt = 1'b1;
      out_let_nxt   = sq_rdata;
      out_rl_nxt    = 1'b0;
      out_me_nxt    = 1'b0;
      out_nk_nxt    = 1'b0;
    end else if (cmd.emit2) begin
      out_valid_nxt = 1'b1;
      out_let_nxt   = sq_rdata;
      out_rl_nxt    = !more_r;
      out_me_nxt    = !more_r && last_r;
      out_nk_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r       <= '0;
      filled_r     <= '0;
      fill_row_r   <= '0;
      fill_col_r   <= '0;
      key_ready_r  <= 1'b0;
      held_r       <= '0;
      held_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      used_r       <= used_nxt;
      filled_r     <= filled_nxt;
      fill_row_r   <= fill_row_nxt;
      fill_col_r   <= fill_col_nxt;
      key_ready_r  <= key_ready_nxt;
      held_r       <= held_nxt;
      held_valid_r <= held_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    let_r     <= let_nxt;
    last_r    <= last_nxt;
    walk_k_r  <= walk_k_nxt;
    cur_a_r   <= cur_a_nxt;
    cur_b_r   <= cur_b_nxt;
    nxt_a_r   <= nxt_a_nxt;
    more_r    <= more_nxt;
    ra_r      <= ra_nxt;
    ca_r      <= ca_nxt;
    idx1_r    <= idx1_nxt;
    idx2_r    <= idx2_nxt;
    out_let_r <= out_let_nxt;
    out_rl_r  <= out_rl_nxt;
    out_me_r  <= out_me_nxt;
    out_nk_r  <= out_nk_nxt;
  end

  always_comb begin
    stat.cmd       = cmd_r;
    stat.key_ready = key_ready_r;
    stat.pair_any  = held_valid_r || last_r;
    stat.pair_more = more_r;
    stat.walk_last = (walk_k_r == LAST_LETTER);
    stat.out_free  = out_free;
  end

  assign out_valid         = out_valid_r;
  assign out_cipher_letter = out_let_r;
  assign out_run_last      = out_rl_r;
  assign out_message_end   = out_me_r;
  assign out_not_keyed     = out_nk_r;

  // a finished square always holds all 25 cells
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    key_ready_r |-> (filled_r == CELL_COUNT))
    else $error("key square marked ready while not full");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    filled_r <= CELL_COUNT)
    else $error("cell count past square size");

  a_ready_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(key_ready_r) |-> $past(cmd.walk_place))
    else $error("key ready set outside the alphabet walk");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_err || cmd.emit1 || cmd.emit2) |-> out_free)
    else $error("result loaded over one not yet taken");

endmodule
`default_nettype wire

>>> rtl/core/playfair_encryptor_core.sv
`default_nettype none
// Playfair encryptor. Requests carry a command: key letter, finish key, message
// letter or clear. Key letters (j folded to i, repeats skipped) fill a 5x5
// square; finish key appends the unused letters in alphabet order. Message
// letters are paired (x inserted in doubled pairs but xx, x pads an odd tail) and
// each pair yields two cipher letters; a message letter before the key is
// finished yields one result with not_keyed set. Key letter and clear pass the
// decode state; finish key walks the alphabet, one letter per cycle, unless the
// key is already finished; a message letter works each pair it completes through
// the read, calc, cell and emit states (error state if not keyed); emit and error
// states wait out an output stall. The letter-position and square tables each
// have one read port, read twice per pair in sequence. One request is worked at
// a time; the result register lets a new request in while a result waits.
module playfair_encryptor_core (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_cmd,
  input  wire logic [4:0] in_letter,
  input  wire logic       in_last,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [4:0]      out_cipher_letter,
  output logic            out_run_last,
  output logic            out_message_end,
  output logic            out_not_keyed
);
  import pfe_pkg::*;

  pfe_cmd_t  cmd;
  pfe_stat_t stat;

  pfe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pfe_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_cmd            (in_cmd),
    .in_letter         (in_letter),
    .in_last           (in_last),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_cipher_letter (out_cipher_letter),
    .out_run_last      (out_run_last),
    .out_message_end   (out_message_end),
    .out_not_keyed     (out_not_keyed)
  );

endmodule
`default_nettype wire

>>> dv/playfair_encryptor_checker.sv
module playfair_encryptor_checker (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_ready,
  input  wire logic [1:0] in_cmd,
  input  wire logic [4:0] in_letter,
  input  wire logic       in_last,
  input  wire logic       out_valid,
  input  wire logic       out_ready,
  input  wire logic [4:0] out_cipher_letter,
  input  wire logic       out_run_last,
  input  wire logic       out_message_end,
  input  wire logic       out_not_keyed,
  output int unsigned     mismatches,
  output int unsigned     outstanding,
  output int unsigned     results_seen,
  output int unsigned     unkeyed_seen
);
  import pfe_pkg::*;

  typedef struct packed {
    logic [4:0] letter;
    logic       run_last;
    logic       msg_end;
    logic       unkeyed;
  } cipher_res_t;

  // shadow of the key square
  logic [4:0]  square [CELLS];
  logic [2:0]  row_of [ALPHA];
  logic [2:0]  col_of [ALPHA];
  logic        placed [ALPHA];
  int unsigned fill_n;
  logic        keyed;
  logic [4:0]  held;
  logic        held_v;

  cipher_res_t cipher_due [$];
  cipher_res_t burst [4];
  int unsigned burst_n;
  int unsigned fail_n = 0;
  int unsigned seen_n = 0;
  int unsigned unkeyed_n = 0;

  task automatic place(input logic [4:0] c);
    if (placed[c] || fill_n >= CELLS) return;
    square[fill_n] = c;
    row_of[c] = 3'(fill_n / SIDE);
    col_of[c] = 3'(fill_n % SIDE);
    placed[c] = 1'b1;
    fill_n++;
  endtask

  task automatic add_pair(input logic [4:0] a, input logic [4:0] b);
    int unsigned ra, ca, rb, cb, t;
    ra = row_of[a];
    ca = col_of[a];
    rb = row_of[b];
    cb = col_of[b];
    if (ra == rb) begin
      ca = (ca + 1) % SIDE;
      cb = (cb + 1) % SIDE;
    end else if (ca == cb) begin
      ra = (ra + 1) % SIDE;
      rb = (rb + 1) % SIDE;
    end else begin
      t = ca;
      ca = cb;
      cb = t;
    end
    burst[burst_n] = cipher_res_t'({square[ra * SIDE + ca], 3'b000});
    burst[burst_n + 1] = cipher_res_t'({square[rb * SIDE + cb], 3'b000});
    burst_n += 2;
  endtask

  task automatic wipe_square();
    int unsigned k;
    for (k = 0; k < ALPHA; k++) placed[k] = 1'b0;
    fill_n = 0;
    keyed = 1'b0;
    held_v = 1'b0;
    held = '0;
  endtask

  task automatic predict_request(input logic [1:0] cmd, input logic [4:0] raw,
                                 input logic last);
    logic [4:0] c;
    int unsigned k;
    c = (raw > LETTER_Z) ? LETTER_Z : raw;
    if (c == LETTER_J) c = LETTER_I;
    burst_n = 0;
    case (cmd)
      CMD_KEY: begin
        if (!keyed) place(c);
      end
      CMD_FINISH: begin
        if (!keyed) begin
          for (k = 0; k < ALPHA; k++)
            if (k != LETTER_J) place(5'(k));
          keyed = 1'b1;
        end
      end
      CMD_CLEAR: begin
        wipe_square();
      end
      default: begin
        if (!keyed) begin
          // letter dropped, pending pair kept
          cipher_due.push_back(cipher_res_t'({5'd0, 1'b1, 1'b0, 1'b1}));
        end else begin
          if (held_v) begin
            if (held == c && c != LETTER_X) begin
              add_pair(held, LETTER_X);
              held = c;
            end else begin
              add_pair(held, c);
              held_v = 1'b0;
            end
          end else begin
            held = c;
            held_v = 1'b1;
          end
          if (last && held_v) begin
            add_pair(held, LETTER_X);
            held_v = 1'b0;
          end
          for (k = 0; k < burst_n; k++) begin
            if (k == burst_n - 1) begin
              burst[k].run_last = 1'b1;
              burst[k].msg_end = last;
            end
            cipher_due.push_back(burst[k]);
          end
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [4:0] want_v,
                             input logic [4:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want_v, got_v);
      fail_n++;
    end
  endtask

  always @(posedge clk) begin : watch
    cipher_res_t want;
    if (!rst_n) begin
      wipe_square();
      cipher_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (cipher_due.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual letter %0d", $time,
                   out_cipher_letter);
          fail_n++;
        end else begin
          want = cipher_due.pop_front();
          seen_n++;
          if (want.unkeyed) unkeyed_n++;
          check_field("cipher_letter", want.letter, out_cipher_letter);
          check_field("run_last", {4'd0, want.run_last}, {4'd0, out_run_last});
          check_field("message_end", {4'd0, want.msg_end}, {4'd0, out_message_end});
          check_field("not_keyed", {4'd0, want.unkeyed}, {4'd0, out_not_keyed});
        end
      end
      if (in_valid && in_ready) predict_request(in_cmd, in_letter, in_last);
    end
    mismatches <= fail_n;
    outstanding <= cipher_due.size();
    results_seen <= seen_n;
    unkeyed_seen <= unkeyed_n;
  end

endmodule

>>> dv/tb_playfair_encryptor_core.sv
module tb_playfair_encryptor_core;
  import pfe_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned REQ_GOAL    = 200;
  localparam int unsigned TAIL_CYCLES = 40;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_cmd = CMD_KEY;
  logic [4:0] in_letter = '0;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [4:0] out_cipher_letter;
  logic       out_run_last;
  logic       out_message_end;
  logic       out_not_keyed;

  int unsigned mismatches, outstanding, results_seen, unkeyed_seen;
  int unsigned sent_n = 0;
  int unsigned cycle_n = 0;
  int unsigned stall_left = 0;
  int unsigned tx_gap_pct = 0;
  int unsigned rx_stall_pct = 0;

  playfair_encryptor_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_letter        (in_letter),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_cipher_letter(out_cipher_letter),
    .out_run_last     (out_run_last),
    .out_message_end  (out_message_end),
    .out_not_keyed    (out_not_keyed)
  );

  playfair_encryptor_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_letter        (in_letter),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_cipher_letter(out_cipher_letter),
    .out_run_last     (out_run_last),
    .out_message_end  (out_message_end),
    .out_not_keyed    (out_not_keyed),
    .mismatches       (mismatches),
    .outstanding      (outstanding),
    .results_seen     (results_seen),
    .unkeyed_seen     (unkeyed_seen)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [4:0] rand_letter();
    if ($urandom_range(0, 19) == 0) return 5'($urandom_range(26, 31));
    return 5'($urandom_range(0, 25));
  endfunction

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < rx_stall_pct) begin
      stall_left <= gap_len() - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_req(input logic [1:0] cmd, input logic [4:0] letter, input logic last);
    int unsigned gap;
    in_cmd <= cmd;
    in_letter <= letter;
    in_last <= last;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sent_n++;
    gap = ($urandom_range(0, 99) < tx_gap_pct) ? gap_len() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold off new requests until every pending cipher letter is out,
  // then leave room for a finish-key walk still running
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic run_session();
    int unsigned nkey, nmsg, len, k;
    logic [4:0] prev, cur;
    if ($urandom_range(0, 3) != 0) send_req(CMD_CLEAR, rand_letter(), 1'($urandom));
    nkey = $urandom_range(0, 10);
    repeat (nkey) send_req(CMD_KEY, rand_letter(), 1'($urandom));
    if ($urandom_range(0, 7) == 0) send_req(CMD_MSG, rand_letter(), 1'($urandom));
    send_req(CMD_FINISH, rand_letter(), 1'($urandom));
    nmsg = $urandom_range(1, 3);
    repeat (nmsg) begin
      len = $urandom_range(1, 8);
      prev = rand_letter();
      for (k = 0; k < len; k++) begin
        // bias toward doubled letters and x filler collisions
        if ($urandom_range(0, 4) == 0) cur = prev;
        else if ($urandom_range(0, 9) == 0) cur = LETTER_X;
        else cur = rand_letter();
        send_req(CMD_MSG, cur, k == len - 1);
        prev = cur;
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // message before any key
    send_req(CMD_MSG, 5'd5, 1'b0);
    // key: above-z clamps to z, j folds to i, repeated i skipped
    send_req(CMD_KEY, 5'd31, 1'b0);
    send_req(CMD_KEY, LETTER_J, 1'b1);
    send_req(CMD_KEY, LETTER_I, 1'b0);
    send_req(CMD_KEY, 5'd0, 1'b0);
    send_req(CMD_MSG, 5'd3, 1'b1);
    send_req(CMD_FINISH, 5'd0, 1'b0);
    send_req(CMD_FINISH, 5'd31, 1'b1);
    send_req(CMD_KEY, 5'd4, 1'b0);
    // square rows: z i a b c / d e f g h / k l m n o / p q r s t / u v w x y
    send_req(CMD_MSG, 5'd0, 1'b0);
    send_req(CMD_MSG, 5'd1, 1'b0);
    send_req(CMD_MSG, 5'd3, 1'b0);
    send_req(CMD_MSG, 5'd15, 1'b0);
    send_req(CMD_MSG, 5'd4, 1'b0);
    send_req(CMD_MSG, 5'd18, 1'b0);
    send_req(CMD_MSG, LETTER_X, 1'b0);
    send_req(CMD_MSG, LETTER_X, 1'b0);
    send_req(CMD_MSG, 5'd24, 1'b0);
    send_req(CMD_MSG, 5'd22, 1'b0);
    send_req(CMD_MSG, 5'd24, 1'b0);
    send_req(CMD_MSG, 5'd2, 1'b0);
    // doubled pair on the final letter: four results
    send_req(CMD_MSG, 5'd11, 1'b0);
    send_req(CMD_MSG, 5'd11, 1'b1);
    send_req(CMD_MSG, 5'd28, 1'b1);
    send_req(CMD_CLEAR, 5'd0, 1'b0);
    send_req(CMD_MSG, 5'd7, 1'b1);
    drain();

    while (sent_n < REQ_GOAL) begin
      case ($urandom_range(0, 3))
        0: begin
          tx_gap_pct = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_gap_pct = 60;
          rx_stall_pct = 60;
        end
        default: begin
          tx_gap_pct = 30;
          rx_stall_pct = 30;
        end
      endcase
      if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(1, 4))
          send_req(2'($urandom), 5'($urandom), 1'($urandom));
      end else begin
        run_session();
      end
      if ($urandom_range(0, 5) == 0) drain();
    end
    drain();

    $display("covered %0d requests: key build, finish, clear, pairing and error paths",
             sent_n);
    $display("checked %0d cipher results, %0d of them not-keyed errors",
             results_seen, unkeyed_seen);
    if (mismatches == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/pfe_pkg.sv
rtl/core/pfe_ram.sv
rtl/core/pfe_ctrl.sv
rtl/core/pfe_dp.sv
rtl/core/playfair_encryptor_core.sv
dv/playfair_encryptor_checker.sv
dv/tb_playfair_encryptor_core.sv
